### sv/fths_pkg.sv
package fths_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 4096;
  localparam int unsigned QUEUE_CAP       = 64;

  localparam int unsigned CNT_W  = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned LEN_W  = CNT_W + 1;
  localparam int unsigned NQ_W   = 7;
  localparam int unsigned Q_W    = 6;
  localparam int unsigned DIV_W  = 32;
  localparam int unsigned STEP_W = $clog2(DIV_W);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES - 1);
  localparam logic [NQ_W-1:0]  NQ_MAX  = NQ_W'(QUEUE_CAP);

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [31:0] MIX_C1    = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_C2    = 32'hc2b2_ae35;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_QUEUES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_INDEX = 2'd2;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        parsed_ok;
    logic [31:0] flow_hash;
    logic [5:0]  target_queue;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [7:0]  protocol;
  } out_word_t;

  typedef struct packed {
    logic [NQ_W-1:0] num_queues;
    logic            fallback_mode;
    logic [7:0]      fallback_index;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;
    logic check;
    logic mul1;
    logic mul2;
    logic fin;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### sv/fths_ctrl.sv
module fths_ctrl import fths_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_stall_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  localparam logic [2:0] ST_CAP   = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_MUL2  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  assign in_stall_o = (state_q != ST_CAP);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_CAP: begin
        cmd_o.take_byte = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_CAP;
        end
      end
      default: begin
        state_d = ST_CAP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CAP;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

### sv/fths_dp.sv
module fths_dp import fths_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_word_t  in_word_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  // capture state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [15:0]      etype_q, etype_d;
  logic [3:0]       words_q, words_d;
  logic [7:0]       proto_q, proto_d;
  logic [31:0]      src_q, src_d;
  logic [31:0]      dst_q, dst_d;
  logic [15:0]      sport_q, sport_d;
  logic [15:0]      dport_q, dport_d;
  logic [31:0]      rr_q;

  // finish state
  logic             ok_q;
  logic [NQ_W-1:0]  nq_q;
  logic [31:0]      hash_q;
  logic [DIV_W-1:0] div_q;
  logic [Q_W-1:0]   rem_q;
  logic             out_valid_q;
  out_word_t        out_q;

  logic [7:0]       b;
  logic [3:0]       words_now;
  logic [CNT_W-1:0] port_off, port_diff;
  logic [1:0]       lane;

  always_comb begin
    b         = in_word_i.pkt_byte;
    cnt_d     = cnt_q;
    len_d     = len_q;
    etype_d   = etype_q;
    words_d   = words_q;
    proto_d   = proto_q;
    src_d     = src_q;
    dst_d     = dst_q;
    sport_d   = sport_q;
    dport_d   = dport_q;
    lane      = cnt_q[1:0] + 2'd2;
    words_now = (cnt_q == CNT_W'(14)) ? b[3:0] : words_q;
    port_off  = CNT_W'({words_now, 2'b00}) + CNT_W'(14);
    port_diff = cnt_q - port_off;
    if (cmd_i.take_byte) begin
      if (cnt_q == CNT_W'(12)) begin
        etype_d[15:8] = b;
      end else if (cnt_q == CNT_W'(13)) begin
        etype_d[7:0] = b;
      end else if (cnt_q == CNT_W'(14)) begin
        words_d = b[3:0];
      end else if (cnt_q == CNT_W'(23)) begin
        proto_d = b;
      end else if (cnt_q >= CNT_W'(26) && cnt_q <= CNT_W'(29)) begin
        src_d[{lane, 3'b000} +: 8] = src_q[{lane, 3'b000} +: 8] | b;
      end else if (cnt_q >= CNT_W'(30) && cnt_q <= CNT_W'(33)) begin
        dst_d[{lane, 3'b000} +: 8] = dst_q[{lane, 3'b000} +: 8] | b;
      end
      // ports may start at byte 14 itself
      if (cnt_q >= port_off && port_diff < CNT_W'(4)) begin
        case (port_diff[1:0])
          2'd0:    sport_d[15:8] = b;
          2'd1:    sport_d[7:0]  = b;
          2'd2:    dport_d[15:8] = b;
          default: dport_d[7:0]  = b;
        endcase
      end
      if (in_word_i.last_byte) begin
        len_d = LEN_W'(cnt_q) + 1'b1;
        cnt_d = '0;
      end else if (cnt_q < CNT_MAX) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (cmd_i.load_out) begin
      etype_d = '0;
      words_d = '0;
      proto_d = '0;
      src_d   = '0;
      dst_d   = '0;
      sport_d = '0;
      dport_d = '0;
    end
  end

  // frame checks, valid once the last byte is in
  logic             is_l4;
  logic [LEN_W-1:0] l4_off;
  logic             parse_ok;
  logic [15:0]      sp_sel, dp_sel;
  logic [31:0]      h0;

  always_comb begin
    is_l4    = (proto_q == PROTO_TCP) || (proto_q == PROTO_UDP);
    l4_off   = LEN_W'({words_q, 2'b00}) + LEN_W'(14);
    parse_ok = (len_q >= LEN_W'(34)) && (etype_q == ETH_IPV4);
    if (proto_q == PROTO_TCP && len_q < l4_off + LEN_W'(20)) begin
      parse_ok = 1'b0;
    end
    if (proto_q == PROTO_UDP && len_q < l4_off + LEN_W'(8)) begin
      parse_ok = 1'b0;
    end
    sp_sel = is_l4 ? sport_q : 16'h0;
    dp_sel = is_l4 ? dport_q : 16'h0;
    h0     = src_q ^ dst_q ^ {sp_sel, dp_sel} ^ {24'h0, proto_q};
  end

  // one shared 32x32 multiplier, low word kept
  logic [31:0] mul_a, mul_b;
  logic [31:0] mul_lo;

  always_comb begin
    if (cmd_i.mul2) begin
      mul_a = hash_q ^ (hash_q >> 13);
      mul_b = MIX_C2;
    end else begin
      mul_a = hash_q;
      mul_b = MIX_C1;
    end
    mul_lo = mul_a * mul_b;
  end

  // restoring remainder, one dividend bit per step
  logic [NQ_W-1:0] trial, trial_red;

  always_comb begin
    trial     = {rem_q, div_q[DIV_W-1]};
    trial_red = (trial >= nq_q) ? (trial - nq_q) : trial;
  end

  logic [NQ_W-1:0] nq_eff;

  always_comb begin
    nq_eff = cfg_i.num_queues;
    if (nq_eff == '0) begin
      nq_eff = NQ_W'(1);
    end
    if (nq_eff > NQ_MAX) begin
      nq_eff = NQ_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      ok_q   <= parse_ok;
      nq_q   <= nq_eff;
      hash_q <= h0 ^ (h0 >> 16);
      if (cfg_i.fallback_mode) begin
        div_q <= {24'h0, cfg_i.fallback_index};
      end else begin
        div_q <= rr_q;
      end
    end
    if (cmd_i.mul1 || cmd_i.mul2) begin
      hash_q <= mul_lo;
    end
    if (cmd_i.fin) begin
      rem_q <= '0;
      if (ok_q) begin
        hash_q <= hash_q ^ (hash_q >> 16);
        div_q  <= hash_q ^ (hash_q >> 16);
      end else begin
        hash_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_red[Q_W-1:0];
      div_q <= {div_q[DIV_W-2:0], 1'b0};
    end
    if (cmd_i.load_out) begin
      out_q.parsed_ok    <= ok_q;
      out_q.flow_hash    <= hash_q;
      out_q.target_queue <= rem_q;
      out_q.src_ip       <= ok_q ? src_q : 32'h0;
      out_q.dst_ip       <= ok_q ? dst_q : 32'h0;
      out_q.l4_sport     <= ok_q ? sp_sel : 16'h0;
      out_q.l4_dport     <= ok_q ? dp_sel : 16'h0;
      out_q.protocol     <= ok_q ? proto_q : 8'h0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      len_q       <= '0;
      etype_q     <= '0;
      words_q     <= '0;
      proto_q     <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      sport_q     <= '0;
      dport_q     <= '0;
      rr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      etype_q <= etype_d;
      words_q <= words_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      sport_q <= sport_d;
      dport_q <= dport_d;
      if (cmd_i.check && !parse_ok && !cfg_i.fallback_mode) begin
        rr_q <= rr_q + 32'd1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_word_o     = out_q;

endmodule

### sv/flow_tuple_hash_steering.sv
// Five-tuple flow hash steering. Frame bytes enter one word per cycle in wire
// order, the final byte flagged by last_byte. The block picks the ethertype,
// IPv4 header length, protocol, addresses (little-endian loads) and TCP/UDP
// ports out of the stream, and after the final byte emits one result word: the
// five-tuple, a murmur-finalizer hash and hash mod num_queues, or for frames
// that do not parse a queue from a round-robin counter or a fixed fallback
// index. Rate: header and payload bytes are taken at one word per cycle when
// the input is not stalled; after the last byte the input stalls for the parse
// check, two passes through the single 32x32 multiplier, final mix, a 32-step
// bit-serial remainder unit and the hand-off into the output register, and
// longer while the result waits for a free output register.
// The result sits in an output register, so the next frame streams in while
// it waits to be taken. Config words are taken at any time (ready is tied
// high) but should only be written while no frame is in flight.
module flow_tuple_hash_steering import fths_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // byte stream in
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  // result out
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  // config writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  // config registers; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_queues     <= NQ_W'(4);
      cfg_q.fallback_mode  <= 1'b0;
      cfg_q.fallback_index <= 8'h0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NUM_QUEUES:     cfg_q.num_queues     <= cfg_data_i[NQ_W-1:0];
        CFG_FALLBACK_MODE:  cfg_q.fallback_mode  <= cfg_data_i[0];
        CFG_FALLBACK_INDEX: cfg_q.fallback_index <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // sequencer: capture, check, mix, remainder, hand-off
  fths_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_word_i.last_byte),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // header capture, hash mixer, remainder unit and output register
  fths_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
